FILE: src/forward_motion_trajectory_cost_defines.svh
// assertion macros for the forward motion trajectory cost block
`ifndef FORWARD_MOTION_TRAJECTORY_COST_DEFINES_SVH
`define FORWARD_MOTION_TRAJECTORY_COST_DEFINES_SVH

// same-cycle implication, off during reset
`define FMTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FMTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fmtc_pkg.sv
// shared constants, codes and arithmetic helpers of the forward motion trajectory cost block
package fmtc_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int COST_W    = 48;
    localparam int SQ_W      = 64;
    localparam int PROD_W    = 64;
    localparam int ACC_W     = 96;
    localparam int IN_DATA_W = 3 * COORD_W + COST_W;

    localparam logic [COST_W-1:0] Q_ONE = COST_W'(1) << FRAC_BITS;

    // item kinds carried on tuser
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_PATH  = 2'd1;
    localparam logic [1:0] FUNC_SPEED = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_POWER     = 3'd1;
    localparam logic [2:0] REG_WEIGHT    = 3'd2;
    localparam logic [2:0] REG_GOAL_TOL  = 3'd3;
    localparam logic [2:0] REG_MIN_SPEED = 3'd4;
    localparam logic [2:0] REG_MAX_DEV   = 3'd5;
    localparam logic [2:0] REG_TIME_STEP = 3'd6;

    // operations run through the shared multiplier
    localparam logic [3:0] OP_PATH_X = 4'd0;
    localparam logic [3:0] OP_PATH_Y = 4'd1;
    localparam logic [3:0] OP_DEV    = 4'd2;
    localparam logic [3:0] OP_GOAL_X = 4'd3;
    localparam logic [3:0] OP_GOAL_Y = 4'd4;
    localparam logic [3:0] OP_TOL    = 4'd5;
    localparam logic [3:0] OP_TS     = 4'd6;
    localparam logic [3:0] OP_WT     = 4'd7;
    localparam logic [3:0] OP_POW    = 4'd8;

    // full product shifted down by the fraction bits, saturated to the cost width
    function automatic logic [COST_W-1:0] mulq_trunc(input logic [ACC_W-1:0] acc);
        logic [COST_W-1:0] r;
        if (|acc[ACC_W-1:COST_W+FRAC_BITS])
            r = '1;
        else
            r = acc[COST_W+FRAC_BITS-1:FRAC_BITS];
        return r;
    endfunction

    // magnitude of a - b, always fits the coordinate width
    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    // sum of two squares, saturated
    function automatic logic [SQ_W-1:0] sat_sq_sum(input logic [SQ_W-1:0] a,
                                                   input logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? '1 : s[SQ_W-1:0];
    endfunction

endpackage

FILE: src/forward_motion_trajectory_cost.sv
// forward motion trajectory cost: pose and path tracking, speed penalty sum, cost update
//
//  channel   | direction | handshake          | content
//  s_*       | in        | s_tvalid/s_tready  | kind on tuser, pose/point/sample on tdata, tlast
//  m_*       | out       | m_tvalid/m_tready  | updated cost on tdata, penalty flag on tuser
//  cfg_*     | in        | cfg_we             | register index and write data, no read-back
//
// one item at a time; all products share one 32x32 multiplier, as partial products in S_MUL
// and S_ACC, then S_POST uses the result (one per square, four per Q.F product); path
// point: two squares; sample: one square when the wanted speed is positive; last sample
// with penalty: goal and tolerance squares, time-step and weight products and one per power
// exponent step; a pass-through last sample needs only those squares, or none when
// disabled; a finished result sits in the output register while the next item is taken;
// reset is asynchronous, active low, and restores the register defaults and tracking state
module forward_motion_trajectory_cost (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // coord_x, coord_y, speed, cost_in
    input  logic [1:0]   s_tuser,   // func
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // cost_out
    output logic         m_tuser,   // penalty_applied
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

`include "forward_motion_trajectory_cost_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUTW = 3'd7;

    localparam int CW = fmtc_pkg::COORD_W;
    localparam int KW = fmtc_pkg::COST_W;
    localparam int QW = fmtc_pkg::SQ_W;
    localparam int PW = fmtc_pkg::PROD_W;
    localparam int AW = fmtc_pkg::ACC_W;

    // control and tracking state
    logic [2:0]           state_reg, state_next;
    logic                 enable_reg, enable_next;
    logic [2:0]           power_reg, power_next;
    logic [CW-1:0]        weight_reg, weight_next;
    logic [CW-1:0]        tol_reg, tol_next;
    logic signed [CW-1:0] min_speed_reg, min_speed_next;
    logic [CW-1:0]        max_dev_reg, max_dev_next;
    logic [CW-1:0]        time_step_reg, time_step_next;
    logic [CW-1:0]        robot_x_reg, robot_x_next;
    logic [CW-1:0]        robot_y_reg, robot_y_next;
    logic [CW-1:0]        end_x_reg, end_x_next;
    logic [CW-1:0]        end_y_reg, end_y_next;
    logic [QW-1:0]        nearest_reg, nearest_next;
    logic [KW-1:0]        speed_sum_reg, speed_sum_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [3:0]           op_reg, op_next;
    logic [1:0]           pp_reg, pp_next;
    logic [2:0]           cnt_reg, cnt_next;

    // payload
    logic [1:0]           func_reg, func_next;
    logic [CW-1:0]        cx_reg, cx_next;
    logic [CW-1:0]        cy_reg, cy_next;
    logic [CW-1:0]        spd_reg, spd_next;
    logic [KW-1:0]        cost_reg, cost_next;
    logic                 last_reg, last_next;
    logic [KW-1:0]        mul_a_reg, mul_a_next;
    logic [KW-1:0]        mul_b_reg, mul_b_next;
    logic                 wide_reg, wide_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [QW-1:0]        tmp_reg, tmp_next;
    logic [KW-1:0]        base_reg, base_next;
    logic [KW-1:0]        r_reg, r_next;
    logic [CW-1:0]        eff_reg, eff_next;
    logic [KW-1:0]        res_reg, res_next;
    logic                 res_pa_reg, res_pa_next;
    logic [KW-1:0]        m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer around the shared multiplier
    always_comb
    begin
        logic              launch;
        logic [3:0]        l_op;
        logic [KW-1:0]     l_a;
        logic [KW-1:0]     l_b;
        logic              l_wide;
        logic [CW-1:0]     a_part;
        logic [CW-1:0]     b_part;
        logic [AW-1:0]     shifted;
        logic [KW-1:0]     mq;
        logic [QW-1:0]     sq;
        logic [QW-1:0]     d;
        logic [CW:0]       diff;
        logic [KW:0]       s49;
        logic [CW-1:0]     ad;

        state_next     = state_reg;
        enable_next    = enable_reg;
        power_next     = power_reg;
        weight_next    = weight_reg;
        tol_next       = tol_reg;
        min_speed_next = min_speed_reg;
        max_dev_next   = max_dev_reg;
        time_step_next = time_step_reg;
        robot_x_next   = robot_x_reg;
        robot_y_next   = robot_y_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        nearest_next   = nearest_reg;
        speed_sum_next = speed_sum_reg;
        m_tvalid_next  = m_tvalid_reg;
        op_next        = op_reg;
        pp_next        = pp_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        spd_next       = spd_reg;
        cost_next      = cost_reg;
        last_next      = last_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        wide_next      = wide_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        base_next      = base_reg;
        r_next         = r_reg;
        eff_next       = eff_reg;
        res_next       = res_reg;
        res_pa_next    = res_pa_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        launch = 1'b0;
        l_op   = fmtc_pkg::OP_PATH_X;
        l_a    = '0;
        l_b    = '0;
        l_wide = 1'b0;
        ad     = '0;
        diff   = '0;
        s49    = '0;
        d      = '0;

        mq = fmtc_pkg::mulq_trunc(acc_reg);
        sq = acc_reg[QW-1:0];

        // operand halves for the current partial product
        a_part = pp_reg[0] ? {{(CW-(KW-CW)){1'b0}}, mul_a_reg[KW-1:CW]} : mul_a_reg[CW-1:0];
        b_part = pp_reg[1] ? {{(CW-(KW-CW)){1'b0}}, mul_b_reg[KW-1:CW]} : mul_b_reg[CW-1:0];

        // partial product placed at its weight
        case (pp_reg)
            2'd0:    shifted = {{(AW-PW){1'b0}}, prod_reg};
            2'd1,
            2'd2:    shifted = {prod_reg, {CW{1'b0}}};
            default: shifted = {prod_reg[AW-2*CW-1:0], {(2*CW){1'b0}}};
        endcase

        // output register drains on transfer
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_addr)
                fmtc_pkg::REG_ENABLE:    enable_next    = cfg_wdata[0];
                fmtc_pkg::REG_POWER:     power_next     = cfg_wdata[2:0];
                fmtc_pkg::REG_WEIGHT:    weight_next    = cfg_wdata;
                fmtc_pkg::REG_GOAL_TOL:  tol_next       = cfg_wdata;
                fmtc_pkg::REG_MIN_SPEED: min_speed_next = cfg_wdata;
                fmtc_pkg::REG_MAX_DEV:   max_dev_next   = cfg_wdata;
                fmtc_pkg::REG_TIME_STEP: time_step_next = cfg_wdata;
                default:                 ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    cx_next    = s_tdata[CW-1:0];
                    cy_next    = s_tdata[2*CW-1:CW];
                    spd_next   = s_tdata[3*CW-1:2*CW];
                    cost_next  = s_tdata[3*CW+KW-1:3*CW];
                    last_next  = s_tlast;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                case (func_reg)
                    fmtc_pkg::FUNC_START:
                    begin
                        robot_x_next   = cx_reg;
                        robot_y_next   = cy_reg;
                        nearest_next   = '1;
                        end_x_next     = '0;
                        end_y_next     = '0;
                        speed_sum_next = '0;
                        state_next     = S_IDLE;
                    end
                    fmtc_pkg::FUNC_PATH:
                    begin
                        ad     = fmtc_pkg::abs_diff(cx_reg, robot_x_reg);
                        launch = 1'b1;
                        l_op   = fmtc_pkg::OP_PATH_X;
                        l_a    = {{(KW-CW){1'b0}}, ad};
                        l_b    = {{(KW-CW){1'b0}}, ad};
                    end
                    fmtc_pkg::FUNC_SPEED:
                    begin
                        if (min_speed_reg > $signed(CW'(0)))
                        begin
                            launch = 1'b1;
                            l_op   = fmtc_pkg::OP_DEV;
                            l_a    = {{(KW-CW){1'b0}}, max_dev_reg};
                            l_b    = {{(KW-CW){1'b0}}, max_dev_reg};
                        end
                        else
                        begin
                            eff_next   = min_speed_reg;
                            state_next = S_SUM;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            S_MUL:
            begin
                prod_next  = PW'(a_part) * PW'(b_part);
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next = acc_reg + shifted;
                if (!wide_reg || pp_reg == 2'd3)
                    state_next = S_POST;
                else
                begin
                    pp_next    = pp_reg + 2'd1;
                    state_next = S_MUL;
                end
            end

            // use the finished product and pick the next operation
            S_POST:
            begin
                case (op_reg)
                    fmtc_pkg::OP_PATH_X:
                    begin
                        tmp_next = sq;
                        ad       = fmtc_pkg::abs_diff(cy_reg, robot_y_reg);
                        launch   = 1'b1;
                        l_op     = fmtc_pkg::OP_PATH_Y;
                        l_a      = {{(KW-CW){1'b0}}, ad};
                        l_b      = {{(KW-CW){1'b0}}, ad};
                    end
                    fmtc_pkg::OP_PATH_Y:
                    begin
                        d = fmtc_pkg::sat_sq_sum(tmp_reg, sq);
                        if (d < nearest_reg)
                            nearest_next = d;
                        if (last_reg)
                        begin
                            end_x_next = cx_reg;
                            end_y_next = cy_reg;
                        end
                        state_next = S_IDLE;
                    end
                    fmtc_pkg::OP_DEV:
                    begin
                        eff_next   = (nearest_reg > sq) ? '0 : min_speed_reg;
                        state_next = S_SUM;
                    end
                    fmtc_pkg::OP_GOAL_X:
                    begin
                        tmp_next = sq;
                        ad       = fmtc_pkg::abs_diff(robot_y_reg, end_y_reg);
                        launch   = 1'b1;
                        l_op     = fmtc_pkg::OP_GOAL_Y;
                        l_a      = {{(KW-CW){1'b0}}, ad};
                        l_b      = {{(KW-CW){1'b0}}, ad};
                    end
                    fmtc_pkg::OP_GOAL_Y:
                    begin
                        tmp_next = fmtc_pkg::sat_sq_sum(tmp_reg, sq);
                        launch   = 1'b1;
                        l_op     = fmtc_pkg::OP_TOL;
                        l_a      = {{(KW-CW){1'b0}}, tol_reg};
                        l_b      = {{(KW-CW){1'b0}}, tol_reg};
                    end
                    fmtc_pkg::OP_TOL:
                    begin
                        if (tmp_reg < sq)
                        begin
                            res_next    = cost_reg;
                            res_pa_next = 1'b0;
                            state_next  = S_OUTW;
                        end
                        else
                        begin
                            launch = 1'b1;
                            l_op   = fmtc_pkg::OP_TS;
                            l_a    = speed_sum_reg;
                            l_b    = {{(KW-CW){1'b0}}, time_step_reg};
                            l_wide = 1'b1;
                        end
                    end
                    fmtc_pkg::OP_TS:
                    begin
                        launch = 1'b1;
                        l_op   = fmtc_pkg::OP_WT;
                        l_a    = mq;
                        l_b    = {{(KW-CW){1'b0}}, weight_reg};
                        l_wide = 1'b1;
                    end
                    fmtc_pkg::OP_WT:
                    begin
                        base_next = mq;
                        r_next    = fmtc_pkg::Q_ONE;
                        cnt_next  = power_reg;
                        if (power_reg == 3'd0)
                            state_next = S_FIN;
                        else
                        begin
                            launch = 1'b1;
                            l_op   = fmtc_pkg::OP_POW;
                            l_a    = fmtc_pkg::Q_ONE;
                            l_b    = mq;
                            l_wide = 1'b1;
                        end
                    end
                    fmtc_pkg::OP_POW:
                    begin
                        r_next   = mq;
                        cnt_next = cnt_reg - 3'd1;
                        if (cnt_reg == 3'd1)
                            state_next = S_FIN;
                        else
                        begin
                            launch = 1'b1;
                            l_op   = fmtc_pkg::OP_POW;
                            l_a    = mq;
                            l_b    = base_reg;
                            l_wide = 1'b1;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            // clipped speed shortfall into the running sum
            S_SUM:
            begin
                diff = {eff_reg[CW-1], eff_reg} - {spd_reg[CW-1], spd_reg};
                if (!diff[CW] && (diff != '0))
                begin
                    s49 = {1'b0, speed_sum_reg} + {{(KW+1-CW){1'b0}}, diff[CW-1:0]};
                    speed_sum_next = s49[KW] ? '1 : s49[KW-1:0];
                end
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!enable_reg)
                begin
                    res_next    = cost_reg;
                    res_pa_next = 1'b0;
                    state_next  = S_OUTW;
                end
                else
                begin
                    ad     = fmtc_pkg::abs_diff(robot_x_reg, end_x_reg);
                    launch = 1'b1;
                    l_op   = fmtc_pkg::OP_GOAL_X;
                    l_a    = {{(KW-CW){1'b0}}, ad};
                    l_b    = {{(KW-CW){1'b0}}, ad};
                end
            end

            // saturating cost update
            S_FIN:
            begin
                s49         = {1'b0, cost_reg} + {1'b0, r_reg};
                res_next    = s49[KW] ? '1 : s49[KW-1:0];
                res_pa_next = 1'b1;
                state_next  = S_OUTW;
            end

            S_OUTW:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = res_reg;
                    m_tuser_next   = res_pa_reg;
                    speed_sum_next = '0;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // start an operation on the multiplier
        if (launch)
        begin
            op_next    = l_op;
            mul_a_next = l_a;
            mul_b_next = l_b;
            wide_next  = l_wide;
            acc_next   = '0;
            pp_next    = 2'd0;
            state_next = S_MUL;
        end
    end

    // control, configuration and tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b1;
            power_reg     <= 3'd1;
            weight_reg    <= 32'd327680;
            tol_reg       <= 32'd32768;
            min_speed_reg <= '0;
            max_dev_reg   <= 32'd196608;
            time_step_reg <= 32'd3277;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            nearest_reg   <= '1;
            speed_sum_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            op_reg        <= fmtc_pkg::OP_PATH_X;
            pp_reg        <= 2'd0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            power_reg     <= power_next;
            weight_reg    <= weight_next;
            tol_reg       <= tol_next;
            min_speed_reg <= min_speed_next;
            max_dev_reg   <= max_dev_next;
            time_step_reg <= time_step_next;
            robot_x_reg   <= robot_x_next;
            robot_y_reg   <= robot_y_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            nearest_reg   <= nearest_next;
            speed_sum_reg <= speed_sum_next;
            m_tvalid_reg  <= m_tvalid_next;
            op_reg        <= op_next;
            pp_reg        <= pp_next;
            cnt_reg       <= cnt_next;
        end
    end

    // item, operand and result registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        spd_reg     <= spd_next;
        cost_reg    <= cost_next;
        last_reg    <= last_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        wide_reg    <= wide_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        tmp_reg     <= tmp_next;
        base_reg    <= base_next;
        r_reg       <= r_next;
        eff_reg     <= eff_next;
        res_reg     <= res_next;
        res_pa_reg  <= res_pa_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // checks
    `FMTC_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, s_tvalid && s_tready, state_reg == S_DISP, "accepted item was not dispatched")
    `FMTC_ASSERT_NOW(a_narrow_single, clk, rst_n, state_reg == S_ACC && !wide_reg, pp_reg == 2'd0, "square used more than one partial product")
    `FMTC_ASSERT_NOW(a_pow_count, clk, rst_n, state_reg == S_POST && op_reg == fmtc_pkg::OP_POW, cnt_reg != 3'd0, "power step with exhausted count")
    `FMTC_ASSERT_NOW(a_cost_grows, clk, rst_n, state_reg == S_OUTW, res_reg >= cost_reg, "result cost below input cost")
    `FMTC_ASSERT_NEXT(a_sum_cleared, clk, rst_n, state_reg == S_OUTW && out_free, speed_sum_reg == '0 && m_tvalid, "speed sum not cleared on result")

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the forward motion trajectory cost block
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 150;
    localparam int         LONG_HOLD     = 600;
    localparam int         PHASES        = 12;
    localparam int         RANDOM_ITEMS  = 1860;
    localparam logic [47:0] ONE_Q        = 48'd1 << fmtc_pkg::FRAC_BITS;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] spd;
        logic [47:0]        cost;
        logic               last;
    } item_t;

    typedef struct {
        logic               enable;
        logic [2:0]         power;
        logic [31:0]        weight;
        logic [31:0]        goal_tol;
        logic signed [31:0] min_speed;
        logic [31:0]        max_dev;
        logic [31:0]        time_step;
    } settings_t;

    typedef struct {
        logic [47:0] cost;
        logic        applied;
    } cost_result_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;   // coord_x, coord_y, speed, cost_in
    logic [1:0]   s_tuser = '0;   // func
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;        // cost_out
    logic         m_tuser;        // penalty_applied
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    // settings and tracking state as the block should hold them
    settings_t          cfg_now;
    logic signed [31:0] pose_x, pose_y, goal_x, goal_y;
    logic [63:0]        nearest_sq;
    logic [47:0]        shortfall_sum;

    cost_result_t pending_costs[$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    bit           steady = 1'b0;
    bit           hold_replies = 1'b0;

    forward_motion_trajectory_cost u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // squared euclidean distance, saturating at 64 bits
    function automatic logic [63:0] square_dist(input logic signed [31:0] ax,
                                                input logic signed [31:0] ay,
                                                input logic signed [31:0] bx,
                                                input logic signed [31:0] by);
        logic signed [32:0] dx, dy;
        logic [31:0]        mx, my;
        logic [64:0]        s;
        dx = 33'(ax) - 33'(bx);
        dy = 33'(ay) - 33'(by);
        mx = dx[32] ? 32'(-dx) : dx[31:0];
        my = dy[32] ? 32'(-dy) : dy[31:0];
        s = 65'(64'(mx) * 64'(mx)) + 65'(64'(my) * 64'(my));
        return s[64] ? '1 : s[63:0];
    endfunction

    // Q.F product, floored and saturated to the cost width
    function automatic logic [47:0] qmul(input logic [47:0] a, input logic [47:0] b);
        logic [95:0] p;
        p = 96'(a) * 96'(b);
        return (|p[95:48+fmtc_pkg::FRAC_BITS]) ? '1
                                               : p[48+fmtc_pkg::FRAC_BITS-1:fmtc_pkg::FRAC_BITS];
    endfunction

    function automatic void reset_tracking();
        cfg_now = '{1'b1, 3'd1, 32'd327680, 32'd32768, 32'sd0, 32'd196608, 32'd3277};
        pose_x = '0;
        pose_y = '0;
        goal_x = '0;
        goal_y = '0;
        nearest_sq = '1;
        shortfall_sum = '0;
    endfunction

    // advance the tracking state by one accepted item, queue its cost if it ends a trajectory
    function automatic void track_item(input item_t it);
        logic signed [32:0] wanted;
        logic signed [32:0] shortfall;
        logic [48:0]        sum_wide;
        logic [63:0]        d;
        logic [47:0]        base, term;
        logic [48:0]        total;
        cost_result_t       res;
        int                 k;
        case (it.func)
            fmtc_pkg::FUNC_START:
            begin
                pose_x = it.x;
                pose_y = it.y;
                nearest_sq = '1;
                goal_x = '0;
                goal_y = '0;
                shortfall_sum = '0;
            end
            fmtc_pkg::FUNC_PATH:
            begin
                d = square_dist(it.x, it.y, pose_x, pose_y);
                if (d < nearest_sq)
                    nearest_sq = d;
                if (it.last)
                begin
                    goal_x = it.x;
                    goal_y = it.y;
                end
            end
            fmtc_pkg::FUNC_SPEED:
            begin
                // wanted speed drops to zero when far off the path
                wanted = 33'(cfg_now.min_speed);
                if (cfg_now.min_speed > 32'sd0 &&
                    nearest_sq > 64'(cfg_now.max_dev) * 64'(cfg_now.max_dev))
                    wanted = '0;
                shortfall = wanted - 33'(it.spd);
                if (shortfall > 33'sd0)
                begin
                    sum_wide = {1'b0, shortfall_sum} + 49'(shortfall[31:0]);
                    shortfall_sum = sum_wide[48] ? '1 : sum_wide[47:0];
                end
                if (it.last)
                begin
                    d = square_dist(pose_x, pose_y, goal_x, goal_y);
                    if (!cfg_now.enable ||
                        d < 64'(cfg_now.goal_tol) * 64'(cfg_now.goal_tol))
                    begin
                        res.cost = it.cost;
                        res.applied = 1'b0;
                    end
                    else
                    begin
                        base = qmul(qmul(shortfall_sum, 48'(cfg_now.time_step)),
                                    48'(cfg_now.weight));
                        term = ONE_Q;
                        for (k = 0; k < int'(cfg_now.power); k++)
                            term = qmul(term, base);
                        total = {1'b0, it.cost} + {1'b0, term};
                        res.cost = total[48] ? '1 : total[47:0];
                        res.applied = 1'b1;
                    end
                    pending_costs.push_back(res);
                    shortfall_sum = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic item_t mk(input logic [1:0] func, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] spd,
                                 input logic [47:0] cost, input logic last);
        item_t it;
        it.func = func;
        it.x = x;
        it.y = y;
        it.spd = spd;
        it.cost = cost;
        it.last = last;
        return it;
    endfunction

    // one input transfer, with a random gap ahead of it unless in steady mode
    task automatic send_item(input item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.cost, it.spd, it.y, it.x};
        s_tuser <= it.func;
        s_tlast <= it.last;
        do @(posedge clk); while (!s_tready);
        track_item(it);
        if (it.func != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(fmtc_pkg::REG_ENABLE, 32'(s.enable));
        write_reg(fmtc_pkg::REG_POWER, 32'(s.power));
        write_reg(fmtc_pkg::REG_WEIGHT, s.weight);
        write_reg(fmtc_pkg::REG_GOAL_TOL, s.goal_tol);
        write_reg(fmtc_pkg::REG_MIN_SPEED, s.min_speed);
        write_reg(fmtc_pkg::REG_MAX_DEV, s.max_dev);
        write_reg(fmtc_pkg::REG_TIME_STEP, s.time_step);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_now = s;
    endtask

    // stop sending, collect every outstanding cost, then let the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random value pickers, biased toward useful ranges and extremes
    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0008_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_wanted();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
        endcase
    endfunction

    function automatic logic [47:0] pick_cost();
        case ($urandom_range(0, 7))
            0: return {16'($urandom), 32'($urandom)};
            1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 32'h0010_0000));
            default: return 48'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] offset_from(input logic [31:0] c);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return c + $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
            2, 3: return c + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return c + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        s.enable = ($urandom_range(0, 5) != 0);
        s.power = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4))
                                              : 3'($urandom_range(0, 7));
        s.weight = pick_scale();
        s.goal_tol = pick_scale();
        s.min_speed = pick_wanted();
        s.max_dev = pick_scale();
        s.time_step = pick_scale();
        return s;
    endfunction

    // one pose, a path and a few trajectories; sometimes a stray item or a dropped or extra end marker
    task automatic run_episode();
        item_t       it;
        logic [31:0] rx, ry;
        int          n_path, n_traj, n_samp;
        int          i, j, k;
        if ($urandom_range(0, 9) == 0)
        begin
            it = mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                    {16'($urandom), 32'($urandom)}, 1'($urandom_range(0, 1)));
            send_item(it);
        end
        else
        begin
            rx = ($urandom_range(0, 7) == 0) ? $urandom : offset_from(32'h0);
            ry = ($urandom_range(0, 7) == 0) ? $urandom : offset_from(32'h0);
            send_item(mk(fmtc_pkg::FUNC_START, rx, ry, $urandom, pick_cost(),
                         1'($urandom_range(0, 1))));
            n_path = $urandom_range(0, 6);
            for (i = 0; i < n_path; i++)
                send_item(mk(fmtc_pkg::FUNC_PATH, offset_from(rx), offset_from(ry), $urandom,
                             pick_cost(),
                             (i == n_path - 1) ^ ($urandom_range(0, 15) == 0)));
            n_traj = $urandom_range(1, 4);
            for (j = 0; j < n_traj; j++)
            begin
                n_samp = $urandom_range(1, 6);
                for (k = 0; k < n_samp; k++)
                    send_item(mk(fmtc_pkg::FUNC_SPEED, $urandom, $urandom, pick_speed(),
                                 pick_cost(),
                                 (k == n_samp - 1) ^ ($urandom_range(0, 15) == 0)));
            end
        end
    endtask

    // directed items under the register defaults
    task automatic test_reset_defaults();
        // sample before any start: robot sits on the default path end
        send_item(mk(fmtc_pkg::FUNC_SPEED, 32'h1234_5678, 32'hEDCB_A987, 32'hFFFF_0000,
                     '1, 1'b1));
        send_item(mk(FUNC_UNUSED, '1, '1, '1, '1, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_START, 32'h000A_0000, 32'hFFFB_0000, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, 1'b0));
        // path end exactly at the goal tolerance: not within it
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h000A_8000, 32'hFFFB_0000, '0, '0, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'h8000_0000, '1, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'h7FFF_FFFF, '0, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'hFFFF_0000, 48'h1, 1'b1));
        // path ends on the robot
        send_item(mk(fmtc_pkg::FUNC_START, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'hFFFE_0000, 48'h3039, 1'b1));
        // path end inside the tolerance
        send_item(mk(fmtc_pkg::FUNC_START, '0, '0, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h0000_4000, '0, '0, '0, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'hFFFE_0000, 48'h3039, 1'b1));
        // no path points, cost saturates
        send_item(mk(fmtc_pkg::FUNC_START, 32'h0003_0000, 32'h0004_0000, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '1, '1, 32'hFFFF_8000, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '1, '1, 32'hFFFF_8000, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '1, '1, 32'hFFFF_8000, 48'hFFFF_FFFF_F000, 1'b1));
    endtask

    // positive wanted speed gated by the path deviation, zero power, disabled block
    task automatic test_wanted_speed_gate();
        settings_t s;
        s = '{1'b1, 3'd0, 32'h0005_0000, 32'h0000_8000, 32'sh0001_0000,
              32'h0003_0000, 32'h0000_0CCD};
        settle();
        apply_settings(s);
        // nearest point exactly at the deviation limit keeps the wanted speed
        send_item(mk(fmtc_pkg::FUNC_START, '0, '0, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h0003_0000, '0, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h0005_0000, 32'h0005_0000, '0, '0, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'h0000_8000, '0, 1'b1));
        // beyond the limit the wanted speed is zero
        send_item(mk(fmtc_pkg::FUNC_START, '0, '0, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_PATH, 32'h0004_0000, '0, '0, '0, 1'b1));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'h0000_8000, 48'h10, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'hFFFF_0000, 48'h10, 1'b1));
        // no path points at all
        send_item(mk(fmtc_pkg::FUNC_START, 32'h0001_0000, '0, '0, '0, 1'b0));
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'h8000_0000, 48'h20, 1'b1));
        s.enable = 1'b0;
        settle();
        apply_settings(s);
        send_item(mk(fmtc_pkg::FUNC_SPEED, '0, '0, 32'h8000_0000, 48'hABCD_EF01_2345, 1'b1));
    endtask

    // random trajectories across register settings, extremes first
    task automatic test_random_trajectories();
        settings_t s;
        int        phase;
        int        target;
        for (phase = 0; phase < PHASES; phase++)
        begin
            s = random_settings();
            case (phase)
                0: s.enable = 1'b0;
                1:
                begin
                    s.enable = 1'b1;
                    s.power = 3'd0;
                    s.weight = '1;
                    s.time_step = '1;
                    s.min_speed = 32'sh7FFF_FFFF;
                end
                2:
                begin
                    s.enable = 1'b1;
                    s.power = 3'd7;
                end
                3:
                begin
                    s.goal_tol = '1;
                    s.max_dev = '1;
                end
                4:
                begin
                    s.enable = 1'b1;
                    s.goal_tol = '0;
                    s.max_dev = '0;
                    s.min_speed = 32'sh8000_0000;
                end
                5:
                begin
                    s.enable = 1'b1;
                    s.power = 3'd4;
                    s.weight = '0;
                    s.time_step = '0;
                end
                6: s = '{1'b1, 3'd1, 32'h0005_0000, 32'h0000_8000, 32'sh0001_0000,
                         32'h0003_0000, 32'h0000_0CCD};
                default: ;
            endcase
            settle();
            apply_settings(s);
            steady = (phase % 4 == 3);
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                run_episode();
        end
        steady = 1'b0;
    endtask

    // receiver holds off while items keep coming, so the block must stall its input
    task automatic test_backpressure();
        int target;
        hold_replies = 1'b1;
        steady = 1'b1;
        target = items_sent + 60;
        while (items_sent < target)
            run_episode();
        steady = 1'b0;
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin : cost_sink
        int stall;
        forever
        begin
            if (hold_replies)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_replies = 1'b0;
            end
            else
            begin
                stall = steady ? 0 : $urandom_range(0, 7);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(rst_n && m_tvalid));
        end
    end

    // compare each result transfer with the oldest predicted cost
    always @(posedge clk)
    begin : check_cost
        cost_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_costs.size() == 0)
            begin
                $error("result transfer with nothing expected: cost_out %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_costs.pop_front();
                if (m_tdata !== want.cost)
                begin
                    $error("cost_out expected %h actual %h", want.cost, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.applied)
                begin
                    $error("penalty_applied expected %b actual %b", want.applied, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        reset_tracking();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_wanted_speed_gate();
        test_random_trajectories();
        test_backpressure();
        settle();
        if (mismatch_count == 0 && pending_costs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
